### sv/rect_to_polar_converter_macros.svh
// ----------------------------------------------------------------------------
// Rectangular-to-polar converter: assertion macros
// Shared helpers for the concurrent checks of the converter.
// ----------------------------------------------------------------------------
`ifndef RECT_TO_POLAR_CONVERTER_MACROS_SVH
`define RECT_TO_POLAR_CONVERTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RTP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/rtp_pkg.sv
// ----------------------------------------------------------------------------
// rtp_pkg
// Types and constants of the rectangular-to-polar converter.
// ----------------------------------------------------------------------------
package rtp_pkg;

  localparam int unsigned DataWidth  = 16;
  localparam int unsigned GuardBits  = 10;
  localparam int unsigned GrowthBits = 3;
  localparam int unsigned XyWidth    = DataWidth + GuardBits + GrowthBits;
  localparam int unsigned ZWidth     = 34;
  localparam int unsigned AngleFrac  = 30;
  localparam int unsigned PhaseFrac  = 13;
  localparam int unsigned PhaseWidth = 16;
  localparam int unsigned GainWidth  = 20;
  localparam int unsigned GainFrac   = 20;
  localparam int unsigned AtanLen    = 32;

  localparam logic [GainWidth-1:0]         GainQ20    = 20'd636757;
  localparam logic signed [ZWidth-1:0]     PiQ30      = 34'sd3373259426;
  localparam logic signed [PhaseWidth-1:0] PiQ13      = 16'sd25736;
  localparam logic signed [PhaseWidth-1:0] HalfPiQ13  = 16'sd12868;

  // atan(2^-i) in radians, Q30, truncated
  localparam logic [31:0] AtanQ30 [AtanLen] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007,
    32'h00000003, 32'h00000001, 32'h00000000, 32'h00000000
  };

  typedef struct packed {
    logic signed [DataWidth-1:0] real_part;
    logic signed [DataWidth-1:0] imag_part;
  } rtp_sample_t;

  typedef struct packed {
    logic [DataWidth-1:0]         magnitude;
    logic signed [PhaseWidth-1:0] phase_angle;
  } rtp_result_t;

  // Phase forced by an axis-aligned sample
  typedef enum logic [2:0] {
    OvrNone,
    OvrZero,
    OvrPi,
    OvrHalfPi,
    OvrNegHalfPi
  } rtp_ovr_e;

  typedef struct packed {
    logic                     valid;
    rtp_ovr_e                 ovr;
    logic signed [XyWidth-1:0] x;
    logic signed [XyWidth-1:0] y;
    logic signed [ZWidth-1:0]  z;
  } rtp_stage_t;

endpackage

### sv/rect_to_polar_converter.sv
// ----------------------------------------------------------------------------
// rect_to_polar_converter
// Pipelined CORDIC vectoring: complex sample in, magnitude and phase out.
// ----------------------------------------------------------------------------
//  Port group          Dir  Handshake          Payload
//  start_i / busy_o    in   start_i & !busy_o  sample_i  (real_part, imag_part)
//  done_o              out  one-cycle strobe   result_o  (magnitude, phase_angle)
//
//  One item per clock; busy_o stays low, the pipeline never stalls.
//  Registers from input to output: fold register, one register per
//  CORDIC cell, gain-multiply register, result register.
//  Reset clears the fold and cell registers and the valid bits of the
//  output stages; the output data registers are free.
//  The receiver cannot stall; each result is on result_o for one cycle.
// ----------------------------------------------------------------------------
`include "rect_to_polar_converter_macros.svh"

module rect_to_polar_converter #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  rtp_pkg::rtp_sample_t sample_i,
  output logic                done_o,
  output rtp_pkg::rtp_result_t result_o
);
  import rtp_pkg::*;

  localparam int unsigned Latency = CORDIC_STAGES + 3;

  logic       accept;
  rtp_stage_t chain [CORDIC_STAGES+1];

  // fully pipelined: never busy
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // fold into right half plane, scale by guard bits
  rtp_fold u_fold (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .sample_i (sample_i),
    .stage_o  (chain[0])
  );

  // row of micro-rotation cells, cell g rotates by atan(2^-g)
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    rtp_cell #(
      .SHIFT (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (chain[g]),
      .stage_o (chain[g+1])
    );
  end

  // gain compensation and phase formatting
  rtp_post u_post (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .stage_i  (chain[CORDIC_STAGES]),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // every result traces back to an accepted item a fixed latency earlier
  `RTP_ASSERT_IMPL(a_done_latency, clk_i, rst_ni, done_o,
                   $past(accept, Latency), "result without matching item")

  // phase stays within +-pi
  `RTP_ASSERT_IMPL(a_phase_range, clk_i, rst_ni, done_o,
                   (result_o.phase_angle <= PiQ13) && (result_o.phase_angle >= -PiQ13),
                   "phase out of range")

  // an accepted item always comes out after the pipeline latency
  `RTP_ASSERT_IMPL(a_no_loss, clk_i, rst_ni, $past(accept, Latency) && $past(rst_ni, Latency),
                   done_o, "item lost in pipeline")

  // the origin maps to zero magnitude and zero phase
  `RTP_ASSERT_IMPL(a_origin, clk_i, rst_ni,
                   done_o && $past(sample_i == '0, Latency),
                   (result_o.magnitude == '0) && (result_o.phase_angle == '0),
                   "origin not mapped to zero")

endmodule

### sv/rtp_fold.sv
// ----------------------------------------------------------------------------
// rtp_fold
// Input register: folds the sample into the right half plane and scales it.
// ----------------------------------------------------------------------------
module rtp_fold (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  rtp_pkg::rtp_sample_t sample_i,
  output rtp_pkg::rtp_stage_t  stage_o
);
  import rtp_pkg::*;

  logic signed [XyWidth-1:0] re_ext, im_ext;
  logic                      re_neg, im_neg;
  rtp_stage_t                stage_d, stage_q;

  assign re_ext = XyWidth'(sample_i.real_part);
  assign im_ext = XyWidth'(sample_i.imag_part);
  assign re_neg = sample_i.real_part[DataWidth-1];
  assign im_neg = sample_i.imag_part[DataWidth-1];

  always_comb begin
    stage_d.valid = accept_i;
    stage_d.x     = (re_neg ? -re_ext : re_ext) <<< GuardBits;
    stage_d.y     = (re_neg ? -im_ext : im_ext) <<< GuardBits;
    // pi offset rides in the angle accumulator from the start
    if (!re_neg)     stage_d.z = '0;
    else if (im_neg) stage_d.z = -PiQ30;
    else             stage_d.z = PiQ30;

    priority if (sample_i.real_part == '0) begin
      if (sample_i.imag_part == '0) stage_d.ovr = OvrZero;
      else if (im_neg)              stage_d.ovr = OvrNegHalfPi;
      else                          stage_d.ovr = OvrHalfPi;
    end else if (sample_i.imag_part == '0) begin
      stage_d.ovr = re_neg ? OvrPi : OvrZero;
    end else begin
      stage_d.ovr = OvrNone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

### sv/rtp_cell.sv
// ----------------------------------------------------------------------------
// rtp_cell
// One registered CORDIC vectoring micro-rotation by atan(2^-SHIFT).
// ----------------------------------------------------------------------------
module rtp_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rtp_pkg::rtp_stage_t stage_i,
  output rtp_pkg::rtp_stage_t stage_o
);
  import rtp_pkg::*;

  localparam logic signed [ZWidth-1:0] Angle = ZWidth'(AtanQ30[SHIFT]);

  logic signed [XyWidth-1:0] xs, ys;
  rtp_stage_t                stage_d, stage_q;

  assign xs = stage_i.x >>> SHIFT;
  assign ys = stage_i.y >>> SHIFT;

  always_comb begin
    stage_d = stage_i;
    if (!stage_i.y[XyWidth-1]) begin
      stage_d.x = stage_i.x + ys;
      stage_d.y = stage_i.y - xs;
      stage_d.z = stage_i.z + Angle;
    end else begin
      stage_d.x = stage_i.x - ys;
      stage_d.y = stage_i.y + xs;
      stage_d.z = stage_i.z - Angle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

### sv/rtp_post.sv
// ----------------------------------------------------------------------------
// rtp_post
// Gain compensation, phase rounding/saturation and the result register.
// ----------------------------------------------------------------------------
module rtp_post (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rtp_pkg::rtp_stage_t  stage_i,
  output logic                done_o,
  output rtp_pkg::rtp_result_t result_o
);
  import rtp_pkg::*;

  localparam int unsigned MagWidth   = XyWidth - 1;
  localparam int unsigned ProdWidth  = MagWidth + GainWidth;
  localparam int unsigned MagShift   = GuardBits + GainFrac;
  localparam int unsigned PhaseShift = AngleFrac - PhaseFrac;

  localparam logic [ProdWidth-1:0]     MagRound   = ProdWidth'(1) << (MagShift - 1);
  localparam logic signed [ZWidth-1:0] PhaseRound = ZWidth'(1) << (PhaseShift - 1);
  localparam logic signed [ZWidth-1:0] PiWide     = ZWidth'(PiQ13);

  logic [MagWidth-1:0]          x_mag;
  logic [ProdWidth-1:0]         prod_d, prod_q, mag_sum;
  logic signed [ZWidth-1:0]     z_rnd;
  logic signed [ZWidth-1:0]     p_full;
  logic signed [PhaseWidth-1:0] phase_sat, phase_d, phase_q;
  logic                         valid_q, done_q;
  rtp_result_t                  result_d, result_q;

  // stage A: gain multiply, phase rounding, saturation and axis override
  assign x_mag  = stage_i.x[XyWidth-1] ? '0 : stage_i.x[MagWidth-1:0];
  assign prod_d = ProdWidth'(x_mag) * ProdWidth'(GainQ20);
  assign z_rnd  = stage_i.z + PhaseRound;
  assign p_full = z_rnd >>> PhaseShift;

  always_comb begin
    if (p_full > PiWide)       phase_sat = PiQ13;
    else if (p_full < -PiWide) phase_sat = -PiQ13;
    else                       phase_sat = p_full[PhaseWidth-1:0];

    unique case (stage_i.ovr)
      OvrNone:      phase_d = phase_sat;
      OvrZero:      phase_d = '0;
      OvrPi:        phase_d = PiQ13;
      OvrHalfPi:    phase_d = HalfPiQ13;
      OvrNegHalfPi: phase_d = -HalfPiQ13;
      default:      phase_d = phase_sat;
    endcase
  end

  // stage B: round the magnitude
  assign mag_sum              = prod_q + MagRound;
  assign result_d.magnitude   = mag_sum[MagShift +: DataWidth];
  assign result_d.phase_angle = phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= stage_i.valid;
      done_q  <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    phase_q  <= phase_d;
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule
